[hdl/lkr_pkg.sv]
// Shared constants, types and arithmetic helpers for the Lehmer keystream rotation cipher.
package lkr_pkg;

    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned SEED_W   = 16;
    localparam int unsigned GEN_W    = 17;
    localparam int unsigned PROD_W   = 24;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W    = 16;

    localparam int unsigned LKR_MULT    = 75;
    localparam int unsigned LKR_MODULUS = 65537;
    localparam int unsigned LKR_SPAN    = 96;
    localparam int unsigned LKR_BASE    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SEED   = 1'd1;

    localparam logic [GEN_W-1:0] GEN_RESET  = 17'd1;
    localparam logic [SEED_W-1:0] SEED_RESET = 16'd1;

    typedef struct packed {
        logic take;
        logic som;
    } t_step_ctl;

    // One generator step: g * 75 mod 65537 by subtracting the high part from the low half.
    function automatic logic [GEN_W-1:0] lkr_advance(input logic [GEN_W-1:0] g);
        logic [PROD_W-1:0] prod;
        logic [17:0]       diff;
        prod = {7'd0, g} * PROD_W'(LKR_MULT);
        diff = {2'b00, prod[15:0]} - {10'd0, prod[23:16]};
        if (diff[17]) begin
            diff = diff + 18'(LKR_MODULUS);
        end
        return diff[GEN_W-1:0];
    endfunction

    // Remainder by three of a 12-bit value, using 4 mod 3 = 1 to fold base-4 digits.
    function automatic logic [1:0] lkr_mod3(input logic [11:0] v);
        logic [4:0] s;
        s = 5'd0;
        for (int i = 0; i < 6; i++) begin
            s = s + {3'd0, v[2*i +: 2]};
        end
        if (s >= 5'd12) begin
            s = s - 5'd12;
        end
        if (s >= 5'd6) begin
            s = s - 5'd6;
        end
        if (s >= 5'd3) begin
            s = s - 5'd3;
        end
        return s[1:0];
    endfunction

    // Rotation amount: generator value mod 96, where 96 is 3 times 32.
    function automatic logic [CHAR_W-1:0] lkr_key(input logic [GEN_W-1:0] g);
        return {lkr_mod3(g[16:5]), g[4:0]};
    endfunction

    function automatic logic [CHAR_W-1:0] lkr_rotate(input logic [CHAR_W-1:0] ch,
                                                     input logic [CHAR_W-1:0] k,
                                                     input logic dec);
        logic [7:0] off;
        logic [7:0] s;
        if (ch < CHAR_W'(LKR_BASE)) begin
            return ch;
        end
        off = {1'b0, ch} - 8'(LKR_BASE);
        if (dec) begin
            s = off + 8'(LKR_SPAN) - {1'b0, k};
        end else begin
            s = off + {1'b0, k};
        end
        if (s >= 8'(LKR_SPAN)) begin
            s = s - 8'(LKR_SPAN);
        end
        s = s + 8'(LKR_BASE);
        return s[CHAR_W-1:0];
    endfunction

endpackage

[hdl/lkr_gen.sv]
// Lehmer generator state register with seed reload and one step per accepted transaction.
module lkr_gen (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkr_pkg::t_step_ctl           i_ctl,
    input  logic [lkr_pkg::SEED_W-1:0]   i_seed,
    output logic [lkr_pkg::GEN_W-1:0]    o_gen
);

    logic [lkr_pkg::GEN_W-1:0] r_gen;
    logic [lkr_pkg::GEN_W-1:0] n_gen;
    logic [lkr_pkg::GEN_W-1:0] w_base;

    always_comb begin
        w_base = i_ctl.som ? {1'b0, i_seed} : r_gen;
        n_gen  = i_ctl.take ? lkr_pkg::lkr_advance(w_base) : r_gen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= lkr_pkg::GEN_RESET;
        end else begin
            r_gen <= n_gen;
        end
    end

    assign o_gen = r_gen;

endmodule

[hdl/lkr_rot.sv]
// Character stage and output register: rotates each character of 32 or above by the generator value mod 96.
module lkr_rot (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [lkr_pkg::CHAR_W-1:0]  i_char,
    input  logic [lkr_pkg::GEN_W-1:0]   i_gen,
    input  logic                        i_decrypt,
    output logic                        o_ready,
    output logic                        o_valid,
    input  logic                        i_out_ready,
    output logic [lkr_pkg::CHAR_W-1:0]  o_char
);

    logic                        r_a_valid;
    logic [lkr_pkg::CHAR_W-1:0]  r_a_char;
    logic                        r_out_valid;
    logic [lkr_pkg::CHAR_W-1:0]  r_out_char;
    logic                        w_move;
    logic [lkr_pkg::CHAR_W-1:0]  w_rot;

    // While a character waits in the first stage, the generator register holds its value,
    // since a new transaction is only taken when that character moves on.
    assign w_move  = r_a_valid && (!r_out_valid || i_out_ready);
    assign o_ready = !r_a_valid || w_move;
    assign w_rot   = lkr_pkg::lkr_rotate(r_a_char, lkr_pkg::lkr_key(i_gen), i_decrypt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_a_valid <= 1'b1;
            end else if (w_move) begin
                r_a_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_a_char <= i_char;
        end
        if (w_move) begin
            r_out_char <= w_rot;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;

endmodule

[hdl/lehmer_keystream_rotation_cipher.sv]
// Top level of the Lehmer keystream rotation cipher with configuration registers.
// Each transaction carries one 7-bit character and yields one character; it waits in
// the first stage register, and a new transaction is taken every cycle while the output
// side keeps up. At acceptance the 17-bit generator steps to g*75 mod 65537 (reloaded
// from the start seed first when start of message is set); then the character, if 32 or
// above, is rotated inside 32..127 by the generator value mod 96, forward or backward
// by the decrypt mode, and lands in the output register. Configuration writes take
// effect at once and are meant to happen only while no transaction is in flight.
module lehmer_keystream_rotation_cipher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lkr_pkg::CHAR_W-1:0]      i_in_char,
    input  logic                            i_start_of_message,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lkr_pkg::CHAR_W-1:0]      o_out_char,
    input  logic                            i_cfg_we,
    input  logic [lkr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lkr_pkg::CFG_W-1:0]       i_cfg_data
);

    logic                          r_decrypt_mode;
    logic [lkr_pkg::SEED_W-1:0]    r_start_seed;
    logic                          w_take;
    logic [lkr_pkg::GEN_W-1:0]     w_gen;
    lkr_pkg::t_step_ctl            w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt_mode <= 1'b0;
            r_start_seed   <= lkr_pkg::SEED_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lkr_pkg::REG_DECRYPT_MODE: r_decrypt_mode <= i_cfg_data[0];
                lkr_pkg::REG_START_SEED:   r_start_seed   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_take    = i_in_valid && o_in_ready;
    assign w_ctl.take = w_take;
    assign w_ctl.som  = i_start_of_message;

    lkr_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_seed  (r_start_seed),
        .o_gen   (w_gen)
    );

    lkr_rot u_rot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_char      (i_in_char),
        .i_gen       (w_gen),
        .i_decrypt   (r_decrypt_mode),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char      (o_out_char)
    );

    // The modular step never leaves 0..65536.
    a_gen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (w_gen <= 17'd65536))
        else $error("generator left its range");

    // A zero seed pins the generator at zero.
    a_zero_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_start_of_message && (r_start_seed == 16'd0)) |=> (w_gen == 17'd0))
        else $error("zero seed did not hold the generator at zero");

    // Input back-pressure only comes from a full pipeline with a stalled output.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output back-pressure");

    // Control characters pass through unchanged.
    a_ctrl_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (i_in_char < 7'd32) && !o_out_valid) ##1 i_out_ready |=>
            (o_out_valid && (o_out_char == $past(i_in_char, 2))))
        else $error("control character was altered");

endmodule
